// File: rtl/gsme_pkg.sv
// gsme_pkg: shared types, constants and command codes for the GF(2) symmetric
// matrix engine. No dependencies.
`timescale 1ns / 1ps
package gsme_pkg;
   localparam int DIM   = 64;
   localparam int IDX_W = $clog2(DIM);
   localparam int CNT_W = IDX_W + 1;

   typedef enum logic [3:0] {
      CMD_READ = 4'd0, CMD_ADD = 4'd1, CMD_SWAP = 4'd2, CMD_TERM = 4'd3,
      CMD_FLIPW = 4'd4, CMD_FLIPX = 4'd5, CMD_APPEND = 4'd6, CMD_ZERO = 4'd7,
      CMD_DROP = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_RANGE = 2'd1, ST_SIZE = 2'd2
   } status_type;

   // One classified command, passed from the front end to the back end.
   typedef struct packed {
      logic [3:0]       cmd;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [63:0]      sa;
      logic [63:0]      sb;
      logic [1:0]       status;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_PRE, BK_WALK, BK_WRA, BK_WRB, BK_DONE
   } bk_state_type;
endpackage

// File: rtl/gsme_ram.sv
// gsme_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module gsme_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/gsme_front.sv
// gsme_front: accepts commands, checks ranges against the tracked size and
// queues classified jobs (two-entry queue). Depends on gsme_pkg.
`timescale 1ns / 1ps
module gsme_front import gsme_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_cmd,
   input  logic [5:0]         req_index_a,
   input  logic [5:0]         req_index_b,
   input  logic [63:0]        req_set_a,
   input  logic [63:0]        req_set_b,
   output logic               job_valid,
   input  logic               job_ready,
   output job_type            job
);
   // Size as it will be after every queued job; jobs run in order.
   logic [CNT_W-1:0] size_ff, size_in;
   job_type          q_ff [2];
   logic [1:0]       cnt_ff;
   logic             rd_ff, wr_ff;
   job_type          nj;
   logic [63:0]      act, outside;
   logic             a_bad, b_bad, empty, acc, pop;

   always_comb begin
      act   = (size_ff >= CNT_W'(64)) ? '1 : ((64'd1 << size_ff) - 64'd1);
      a_bad = {1'b0, req_index_a} >= 7'(size_ff);
      b_bad = {1'b0, req_index_b} >= 7'(size_ff);
      empty = (size_ff == '0);
      outside = (req_set_a & ~act);
      nj.cmd = req_cmd;
      nj.a = IDX_W'(req_index_a);
      nj.b = IDX_W'(req_index_b);
      nj.sa = req_set_a;
      nj.sb = req_set_b;
      nj.status = ST_OK;
      size_in = size_ff;
      case (req_cmd)
         CMD_READ, CMD_ADD: if (a_bad || b_bad) nj.status = ST_RANGE;
         CMD_ZERO: if (a_bad) nj.status = ST_RANGE;
         CMD_SWAP: if (empty) nj.status = ST_SIZE; else if (a_bad) nj.status = ST_RANGE;
         CMD_TERM: if (empty) nj.status = ST_SIZE;
         CMD_DROP: begin
            if (empty) nj.status = ST_SIZE;
            else size_in = size_ff - 1'b1;
         end
         CMD_FLIPW: if (outside != '0) nj.status = ST_RANGE;
         CMD_FLIPX: if (((req_set_a | req_set_b) & ~act) != '0) nj.status = ST_RANGE;
         CMD_APPEND: begin
            if (size_ff >= CNT_W'(DIM)) nj.status = ST_SIZE;
            else if (outside != '0) nj.status = ST_RANGE;
            else size_in = size_ff + 1'b1;
         end
         default: nj.status = ST_RANGE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign acc = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (acc) q_ff[wr_ff] <= nj;
      if (reset) begin
         size_ff <= '0; cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (acc) begin size_ff <= size_in; wr_ff <= ~wr_ff; end
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, acc} - {1'b0, pop};
      end
   end
endmodule

// File: rtl/gsme_back.sv
// gsme_back: executes queued jobs on the row memory, one row per cycle for
// column updates, and holds the result register. Depends on gsme_pkg, gsme_ram.
`timescale 1ns / 1ps
module gsme_back import gsme_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_entry_bit,
   output logic        rsp_is_zero,
   output logic [63:0] rsp_terminal_set,
   output logic [6:0]  rsp_active_size,
   output logic [1:0]  rsp_status
);
   bk_state_type     state_ff, state_in;
   job_type          j_ff;
   logic [CNT_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] row_ff, row_in;    // row being read
   logic             rv_ff;             // read data valid for prev_ff
   logic [IDX_W-1:0] prev_ff;
   logic [63:0]      rowa_ff, rowb_ff;  // captured rows a/b (or last) after walk
   logic [63:0]      term_ff;
   logic             ebit_ff, zero_ff;
   logic             v_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [63:0]      wr_data, rd_data, act, nrow;
   logic [IDX_W-1:0] last;
   logic             xbit, walk_cmd, rdone;

   gsme_ram #(.WIDTH(64), .DEPTH(DIM)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   assign act  = (r_ff >= CNT_W'(64)) ? '1 : ((64'd1 << r_ff) - 64'd1);
   assign last = IDX_W'(r_ff - 1'b1);
   assign walk_cmd = (j_ff.status == ST_OK) && (j_ff.cmd == CMD_ADD ||
      j_ff.cmd == CMD_SWAP || j_ff.cmd == CMD_TERM || j_ff.cmd == CMD_FLIPW ||
      j_ff.cmd == CMD_FLIPX || j_ff.cmd == CMD_APPEND || j_ff.cmd == CMD_READ ||
      j_ff.cmd == CMD_ZERO);
   assign rdone = ({1'b0, prev_ff} == 7'(r_ff - 1'b1));

   // Per-row update of the walked row prev_ff using its read data.
   always_comb begin
      nrow = rd_data;
      xbit = 1'b0;
      case (j_ff.cmd)
         CMD_ADD: nrow = rd_data ^ (64'(rd_data[j_ff.b]) << j_ff.a);
         CMD_SWAP: begin
            xbit = rd_data[j_ff.a] ^ rd_data[last];
            nrow = rd_data ^ (64'(xbit) << j_ff.a) ^ (64'(xbit) << last);
         end
         CMD_FLIPW:
            if (j_ff.sa[prev_ff]) nrow = rd_data ^ (j_ff.sa & ~(64'd1 << prev_ff));
         CMD_FLIPX: nrow = rd_data ^ (j_ff.sa[prev_ff] ? j_ff.sb : '0)
                                   ^ (j_ff.sb[prev_ff] ? j_ff.sa : '0);
         CMD_APPEND: nrow = (rd_data & ~(64'd1 << r_ff[IDX_W-1:0]))
                          | (64'(j_ff.sa[prev_ff]) << r_ff[IDX_W-1:0]);
         default: nrow = rd_data;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (job_valid && !v_ff) state_in = BK_PRE;
         BK_PRE: begin
            // Skip the walk when no row is active; append still writes row 0.
            if (!walk_cmd) state_in = BK_DONE;
            else if (r_ff == '0) state_in = (j_ff.cmd == CMD_APPEND) ? BK_WRA : BK_DONE;
            else state_in = BK_WALK;
         end
         BK_WALK: if (rv_ff && rdone) state_in = (j_ff.cmd == CMD_ADD ||
                     j_ff.cmd == CMD_SWAP || j_ff.cmd == CMD_APPEND) ? BK_WRA : BK_DONE;
         BK_WRA:  state_in = (j_ff.cmd == CMD_SWAP) ? BK_WRB : BK_DONE;
         BK_WRB:  state_in = BK_DONE;
         BK_DONE: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_ready = (state_ff == BK_IDLE) && !v_ff;
      row_in = row_ff;
      rd_addr = row_ff;
      wr_en = 1'b0;
      wr_addr = prev_ff;
      wr_data = nrow;
      r_in = r_ff;
      case (state_ff)
         BK_PRE: row_in = '0;
         BK_WALK: begin
            if (!rdone || !rv_ff) row_in = row_ff + 1'b1;
            wr_en = rv_ff && (j_ff.cmd == CMD_ADD || j_ff.cmd == CMD_SWAP ||
                    j_ff.cmd == CMD_FLIPW || j_ff.cmd == CMD_FLIPX ||
                    j_ff.cmd == CMD_APPEND);
         end
         BK_WRA: begin
            wr_en = 1'b1;
            if (j_ff.cmd == CMD_ADD) begin
               wr_addr = j_ff.a; wr_data = rowa_ff ^ (rowb_ff & act);
            end else if (j_ff.cmd == CMD_SWAP) begin
               wr_addr = j_ff.a; wr_data = rowb_ff;
            end else begin
               wr_addr = r_ff[IDX_W-1:0]; wr_data = j_ff.sa;
            end
         end
         BK_WRB: begin
            wr_en = 1'b1; wr_addr = last; wr_data = rowa_ff;
         end
         BK_DONE: begin
            if (j_ff.status == ST_OK && j_ff.cmd == CMD_APPEND) r_in = r_ff + 1'b1;
            if (j_ff.status == ST_OK && j_ff.cmd == CMD_DROP)   r_in = r_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && job_valid && !v_ff) j_ff <= job;
      prev_ff <= row_ff;
      row_ff <= row_in;
      if (state_ff == BK_PRE) begin
         term_ff <= '0; ebit_ff <= 1'b0; zero_ff <= 1'b0;
      end
      if (state_ff == BK_WALK && rv_ff) begin
         // As rows pass, capture updated rows a, b (last for swap) and results.
         if (prev_ff == j_ff.a) rowa_ff <= nrow;
         if (j_ff.cmd == CMD_SWAP ? prev_ff == last : prev_ff == j_ff.b) rowb_ff <= nrow;
         if (j_ff.cmd == CMD_TERM && prev_ff != last)
            term_ff[prev_ff] <= rd_data[last];
         if (j_ff.cmd == CMD_READ && prev_ff == j_ff.a) ebit_ff <= rd_data[j_ff.b];
         if (j_ff.cmd == CMD_ZERO && prev_ff == j_ff.a)
            zero_ff <= ((rd_data & act & ~(64'd1 << j_ff.a)) == '0);
      end
      if (reset) begin
         state_ff <= BK_IDLE; r_ff <= '0; rv_ff <= 1'b0; v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         r_ff <= r_in;
         rv_ff <= (state_ff == BK_WALK) && !(rv_ff && rdone);
         if (state_ff == BK_DONE) v_ff <= 1'b1;
         else if (rsp_ready) v_ff <= 1'b0;
      end
   end

   assign rsp_valid        = v_ff;
   assign rsp_entry_bit    = ebit_ff;
   assign rsp_is_zero      = zero_ff;
   assign rsp_terminal_set = term_ff;
   assign rsp_active_size  = 7'(r_ff);
   assign rsp_status       = j_ff.status;
endmodule

// File: rtl/gf2_symmetric_matrix_engine.sv
// gf2_symmetric_matrix_engine: top level joining the command front end and
// the row-walking back end. Depends on gsme_pkg, gsme_front, gsme_back.
//
// Usage: commands enter on the req_ channel (valid/ready); each command
// gives exactly one result on the rsp_ channel, in order. The front end
// checks indices and sets against the size and queues up to two commands,
// so new commands are taken while the back end works or a result waits.
// Commands that fail or need no rows (drop) skip the row walk; commands
// that walk the active rows (read, add, swap, terminal_set, flips,
// append, is_zero) read them through the single memory read port; add
// and append then write one more row, swap two. With no active rows the
// walk is skipped. Reset clears the size to zero and the queue; row
// memory contents are never visible until append rewrites them. When the
// receiver stalls the result holds in its register, the back end waits,
// and the queue fills before req_ready drops.
`timescale 1ns / 1ps
module gf2_symmetric_matrix_engine import gsme_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_cmd,
   input  logic [5:0]  req_index_a,
   input  logic [5:0]  req_index_b,
   input  logic [63:0] req_set_a,
   input  logic [63:0] req_set_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_entry_bit,
   output logic        rsp_is_zero,
   output logic [63:0] rsp_terminal_set,
   output logic [6:0]  rsp_active_size,
   output logic [1:0]  rsp_status
);
   logic    job_valid, job_ready;
   job_type job;

   // Classify and queue commands.
   gsme_front u_front (.clock, .reset, .req_valid, .req_ready, .req_cmd,
      .req_index_a, .req_index_b, .req_set_a, .req_set_b,
      .job_valid, .job_ready, .job);

   // Carry out one command at a time, holding the result until transfer.
   gsme_back u_back (.clock, .reset, .job_valid, .job_ready, .job,
      .rsp_valid, .rsp_ready, .rsp_entry_bit, .rsp_is_zero,
      .rsp_terminal_set, .rsp_active_size, .rsp_status);
endmodule

// File: rtl/gsme_checker.sv
// gsme_checker: port-level assertions for the matrix engine, bound to the top.
// Depends on gsme_pkg.
`timescale 1ns / 1ps
module gsme_checker import gsme_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_entry_bit,
   input logic       rsp_is_zero,
   input logic [6:0] rsp_active_size,
   input logic [1:0] rsp_status
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped or changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status code");
   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_active_size <= 7'(DIM)) else $error("size above DIM");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_entry_bit && !rsp_is_zero)
      else $error("data on failed command");
endmodule

bind gf2_symmetric_matrix_engine gsme_checker u_checker (.clock, .reset,
   .rsp_valid, .rsp_ready, .rsp_entry_bit, .rsp_is_zero, .rsp_active_size,
   .rsp_status);

// File: test/gf2_symmetric_matrix_engine_tb.sv
// gf2_symmetric_matrix_engine_tb: self-checking bench for the GF(2) symmetric
// matrix engine. Depends on gsme_pkg and gf2_symmetric_matrix_engine.
`timescale 1ns / 1ps
module gf2_symmetric_matrix_engine_tb;
   import gsme_pkg::*;

   typedef struct {
      logic [3:0]  cmd;
      logic [5:0]  a;
      logic [5:0]  b;
      logic [63:0] sa;
      logic [63:0] sb;
   } command_type;

   typedef struct {
      logic        entry;
      logic        zero;
      logic [63:0] term;
      logic [6:0]  size;
      logic [1:0]  status;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_cmd = '0;
   logic [5:0]  req_index_a = '0;
   logic [5:0]  req_index_b = '0;
   logic [63:0] req_set_a = '0;
   logic [63:0] req_set_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_entry_bit;
   logic        rsp_is_zero;
   logic [63:0] rsp_terminal_set;
   logic [6:0]  rsp_active_size;
   logic [1:0]  rsp_status;

   command_type pending_cmds[$];
   answer_type  expected_answers[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          stimulus_done = 1'b0;

   // Predictor copy of the matrix: row i, bit j is entry (i,j).
   logic [63:0] mat_rows[64];
   int          mat_size = 0;

   // Remember whether the presented item was taken at the last rising edge.
   logic req_ready_q = 1'b0;

   gf2_symmetric_matrix_engine uut (.*);

   always #10 clock = ~clock;

   function automatic logic [63:0] act_mask(int n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   // Apply one command to the predictor matrix and return what it should answer.
   function automatic answer_type apply_command(command_type c);
      answer_type  ans;
      int          r;
      int          last;
      logic [63:0] act;
      logic [63:0] tmp;
      logic        x;
      logic [63:0] f;
      r = mat_size;
      act = act_mask(r);
      ans = '{1'b0, 1'b0, 64'd0, 7'd0, ST_OK};
      case (c.cmd)
         CMD_READ: begin
            if (c.a >= r || c.b >= r) ans.status = ST_RANGE;
            else ans.entry = mat_rows[c.a][c.b];
         end
         CMD_ADD: begin
            if (c.a >= r || c.b >= r) ans.status = ST_RANGE;
            else begin
               for (int j = 0; j < r; j++)
                  mat_rows[j][c.a] = mat_rows[j][c.a] ^ mat_rows[j][c.b];
               mat_rows[c.a] = mat_rows[c.a] ^ (mat_rows[c.b] & act);
            end
         end
         CMD_SWAP: begin
            if (r == 0) ans.status = ST_SIZE;
            else if (c.a >= r) ans.status = ST_RANGE;
            else begin
               last = r - 1;
               for (int j = 0; j < r; j++) begin
                  x = mat_rows[j][c.a] ^ mat_rows[j][last];
                  mat_rows[j][c.a] = mat_rows[j][c.a] ^ x;
                  mat_rows[j][last] = mat_rows[j][last] ^ x;
               end
               tmp = mat_rows[c.a];
               mat_rows[c.a] = mat_rows[last];
               mat_rows[last] = tmp;
            end
         end
         CMD_TERM: begin
            if (r == 0) ans.status = ST_SIZE;
            else for (int j = 0; j < r - 1; j++) ans.term[j] = mat_rows[j][r-1];
         end
         CMD_FLIPW: begin
            if ((c.sa & ~act) != 0) ans.status = ST_RANGE;
            else for (int j = 0; j < r; j++)
               if (c.sa[j]) mat_rows[j] = mat_rows[j] ^ (c.sa & ~(64'd1 << j));
         end
         CMD_FLIPX: begin
            if (((c.sa | c.sb) & ~act) != 0) ans.status = ST_RANGE;
            else for (int j = 0; j < r; j++) begin
               f = '0;
               if (c.sa[j]) f = f ^ c.sb;
               if (c.sb[j]) f = f ^ c.sa;
               mat_rows[j] = mat_rows[j] ^ f;
            end
         end
         CMD_APPEND: begin
            if (r >= 64) ans.status = ST_SIZE;
            else if ((c.sa & ~act) != 0) ans.status = ST_RANGE;
            else begin
               for (int j = 0; j < r; j++) mat_rows[j][r] = c.sa[j];
               mat_rows[r] = c.sa;
               mat_size = r + 1;
            end
         end
         CMD_ZERO: begin
            if (c.a >= r) ans.status = ST_RANGE;
            else ans.zero = ((mat_rows[c.a] & act & ~(64'd1 << c.a)) == 0);
         end
         CMD_DROP: begin
            if (r == 0) ans.status = ST_SIZE;
            else mat_size = r - 1;
         end
         default: ans.status = ST_RANGE;
      endcase
      ans.size = 7'(mat_size);
      return ans;
   endfunction

   // Stimulus side tracks size so random items land mostly in range.
   int plan_size = 0;

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   task automatic queue_command(logic [3:0] cmd, logic [5:0] a, logic [5:0] b,
                                logic [63:0] sa, logic [63:0] sb);
      command_type c;
      c = '{cmd, a, b, sa, sb};
      if (cmd == CMD_APPEND && plan_size < 64 && (sa & ~act_mask(plan_size)) == 0)
         plan_size++;
      else if (cmd == CMD_DROP && plan_size > 0)
         plan_size--;
      pending_cmds.push_back(c);
   endtask

   // Mostly well-formed commands with indices and sets inside the active range.
   task automatic queue_random();
      int          pick;
      logic [63:0] m;
      logic [5:0]  hi;
      pick = $urandom_range(0, 99);
      m = act_mask(plan_size);
      hi = (plan_size > 0) ? 6'(plan_size - 1) : 6'd0;
      if (pick < 4)
         queue_command(4'($urandom_range(0, 15)), 6'($urandom), 6'($urandom),
                       rand_word(), rand_word());
      else if (pick < 20 || plan_size < 3)
         queue_command(CMD_APPEND, '0, '0,
                       (pick % 7 == 0) ? rand_word() : (rand_word() & m), '0);
      else if (pick < 28)
         queue_command(CMD_DROP, '0, '0, '0, '0);
      else
         queue_command(4'($urandom_range(0, 7)), 6'($urandom_range(0, hi)),
                       6'($urandom_range(0, hi)), rand_word() & m, rand_word() & m);
   endtask

   // Hold until nothing is queued, presented or awaiting its result.
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_answers.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // Driver: present the next pending transfer at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_q) begin
            // previous transfer completed at the last rising edge
         end
         if (!req_valid || req_ready_q) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               command_type c;
               c = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_cmd <= c.cmd;
               req_index_a <= c.a;
               req_index_b <= c.b;
               req_set_a <= c.sa;
               req_set_b <= c.sb;
            end else
               req_valid <= 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on each request transfer, check each result transfer.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_ready_q <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            command_type c;
            c = '{req_cmd, req_index_a, req_index_b, req_set_a, req_set_b};
            expected_answers.push_back(apply_command(c));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0)
               report_mismatch("unexpected result", '0, '0);
            else begin
               answer_type e;
               e = expected_answers.pop_front();
               if (rsp_entry_bit !== e.entry) report_mismatch("entry_bit", rsp_entry_bit, e.entry);
               if (rsp_is_zero !== e.zero) report_mismatch("is_zero", rsp_is_zero, e.zero);
               if (rsp_terminal_set !== e.term)
                  report_mismatch("terminal_set", rsp_terminal_set, e.term);
               if (rsp_active_size !== e.size)
                  report_mismatch("active_size", rsp_active_size, e.size);
               if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            end
         end
      end
   end

   // Watchdog: report failure and stop if the run outlasts the cycle limit, which leaves room for stalls and gaps.
   always @(posedge clock) begin
      if (cycle_count > 600000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-matrix errors, unknown codes, then build and exercise.
      queue_command(CMD_READ, '0, '0, '0, '0);
      queue_command(CMD_SWAP, '0, '0, '0, '0);
      queue_command(CMD_TERM, '0, '0, '0, '0);
      queue_command(CMD_DROP, '0, '0, '0, '0);
      queue_command(CMD_ZERO, '0, '0, '0, '0);
      queue_command(4'd9, 6'd1, 6'd2, '0, '0);
      queue_command(4'd15, '1, '1, '1, '1);
      queue_command(CMD_APPEND, '0, '0, 64'd1, '0);     // set bit out of range
      queue_command(CMD_APPEND, '0, '0, '0, '0);
      queue_command(CMD_APPEND, '0, '0, 64'd1, '0);
      queue_command(CMD_APPEND, '0, '0, 64'd3, '0);
      queue_command(CMD_APPEND, '0, '0, 64'd5, '0);
      queue_command(CMD_TERM, '0, '0, '0, '0);
      queue_command(CMD_FLIPW, '0, '0, 64'hF, '0);
      queue_command(CMD_FLIPX, '0, '0, 64'h3, 64'hC);
      queue_command(CMD_FLIPX, '0, '0, 64'h10, 64'h1);  // out of range
      queue_command(CMD_ADD, 6'd1, 6'd2, '0, '0);
      queue_command(CMD_ADD, 6'd2, 6'd2, '0, '0);       // h equal to k clears
      queue_command(CMD_SWAP, 6'd0, '0, '0, '0);
      queue_command(CMD_READ, 6'd3, 6'd0, '0, '0);
      queue_command(CMD_READ, 6'd4, 6'd0, '0, '0);
      queue_command(CMD_ZERO, 6'd1, '0, '0, '0);
      queue_command(CMD_ZERO, 6'd63, '0, '0, '0);
      wait_drained();

      // Fill to the full size, then hit the extremes.
      send_idle_pct = 59;
      while (plan_size < 64)
         queue_command(CMD_APPEND, '0, '0, rand_word() & act_mask(plan_size), '0);
      queue_command(CMD_APPEND, '0, '0, '0, '0);        // full
      queue_command(CMD_READ, 6'd63, 6'd0, '0, '0);
      queue_command(CMD_FLIPX, '0, '0, '1, rand_word());
      queue_command(CMD_SWAP, 6'd0, '0, '0, '0);
      queue_command(CMD_TERM, '0, '0, '0, '0);
      queue_command(CMD_ZERO, 6'd63, '0, '0, '0);
      wait_drained();

      // Random phases: free run, slow sender, slow receiver, both.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? 59 : 0;
         recv_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 8 : 0;
         if (phase == 3) send_idle_pct = 8;
         for (int n = 0; n < 110; n++) queue_random();
         wait_drained();
      end
      // Drain the size down to zero to close the loop on drop.
      while (plan_size > 0) queue_command(CMD_DROP, '0, '0, '0, '0);
      queue_command(CMD_DROP, '0, '0, '0, '0);
      wait_drained();
      repeat (100) @(posedge clock);

      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
